>>> rtl/ecb_pkg.sv
// ----------------------------------------------------------------------------
// ecb_pkg: shared constants for the ease-in-out colour blend
// widths of the light state, the progress input and the register map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecb_pkg;

  // default fraction bits of the ease value
  localparam int FRAC_BITS_DEF = 16;

  // light state packing: six byte channels in one word
  localparam int CHANNELS = 6;
  localparam int CH_W     = 8;
  localparam int COLOUR_W = CHANNELS * CH_W;

  // progress input, unsigned Q1.16 (one integer bit)
  localparam int PROGRESS_W    = 17;
  localparam int PROGRESS_FRAC = 16;
  localparam logic [PROGRESS_W-1:0] PROGRESS_ONE = PROGRESS_W'(65536);

  // register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = CFG_IDX_W'(1);

endpackage

`default_nettype wire

>>> rtl/ecb_ease.sv
// ----------------------------------------------------------------------------
// ecb_ease: ease curve pipeline
// saturates progress, squares it, forms 2c^2-2c+1 and divides by
// restoring long division, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecb_ease #(
  parameter int FRAC_BITS = ecb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ecb_pkg::PROGRESS_W-1:0]    progress,
  output logic                              ease_valid,
  input  logic                              ease_ready,
  output logic [FRAC_BITS:0]                ease
);
  import ecb_pkg::*;

  localparam int CW   = FRAC_BITS + 1;      // c and quotient width
  localparam int SW   = 2 * FRAC_BITS + 1;  // c^2 width
  localparam int DW   = 2 * FRAC_BITS + 2;  // divisor and remainder width
  localparam int NDIV = FRAC_BITS + 1;      // quotient bits
  localparam int NS   = NDIV + 3;           // total stages

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;

  // stage storage
  logic [CW-1:0] c0_r;
  logic [CW-1:0] c1_r;
  logic [SW-1:0] sq1_r;
  logic [DW-1:0] d_r [0:NDIV-1];
  logic [DW-1:0] r_r [0:NDIV-1];
  logic [CW-1:0] q_r [1:NDIV];

  logic [PROGRESS_W-1:0]           p_sat;
  logic [PROGRESS_W+FRAC_BITS-1:0] p_wide;
  logic [CW-1:0]                   c_nxt;
  logic [SW-1:0]                   sq_nxt;
  logic [DW-1:0]                   den_nxt;

  // a stage moves when it is empty or its successor moves
  assign rdy[NS] = ease_ready;
  genvar gi;
  generate
    for (gi = 0; gi < NS; gi++) begin : g_rdy
      assign rdy[gi] = !v_r[gi] || rdy[gi+1];
    end
  endgenerate

  assign v_in       = {v_r[NS-2:0], in_valid};
  assign in_ready   = rdy[0];
  assign ease_valid = v_r[NS-1];
  assign ease       = q_r[NDIV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  // saturate and rescale to FRAC_BITS fraction bits
  assign p_sat  = (progress > PROGRESS_ONE) ? PROGRESS_ONE : progress;
  assign p_wide = {p_sat, {FRAC_BITS{1'b0}}};
  assign c_nxt  = p_wide[PROGRESS_FRAC +: CW];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c0_r <= c_nxt;
    end
  end

  // square
  assign sq_nxt = SW'(c0_r) * SW'(c0_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      c1_r  <= c0_r;
      sq1_r <= sq_nxt;
    end
  end

  // divisor 2c^2 - 2c*one + one^2, never below one half
  assign den_nxt = {sq1_r, 1'b0} + (DW'(1) << (2 * FRAC_BITS))
                   - {c1_r, {(FRAC_BITS + 1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      d_r[0] <= den_nxt;
      r_r[0] <= DW'(sq1_r);
    end
  end

  // long division, integer bit first then fraction bits
  genvar gj;
  generate
    for (gj = 1; gj <= NDIV; gj++) begin : g_div
      logic [DW-1:0] trial;
      logic [CW-1:0] q_prev;
      logic          ge;

      if (gj == 1) begin : g_first
        assign trial  = r_r[0];
        assign q_prev = '0;
      end else begin : g_next
        assign trial  = r_r[gj-1] << 1;
        assign q_prev = q_r[gj-1];
      end

      assign ge = trial >= d_r[gj-1];

      always_ff @(posedge clk) begin
        if (rdy[gj+2]) begin
          q_r[gj] <= {q_prev[CW-2:0], ge};
        end
      end

      // the last stage keeps only its quotient bit
      if (gj < NDIV) begin : g_carry
        logic [DW-1:0] rem_nxt;

        assign rem_nxt = ge ? (trial - d_r[gj-1]) : trial;

        always_ff @(posedge clk) begin
          if (rdy[gj+2]) begin
            d_r[gj] <= d_r[gj-1];
            r_r[gj] <= rem_nxt;
          end
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

>>> rtl/ecb_lane.sv
// ----------------------------------------------------------------------------
// ecb_lane: one channel of the blend
// from + ease*(to - from), rounded half up, registered as a byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecb_lane #(
  parameter int FRAC_BITS = ecb_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ecb_pkg::CH_W-1:0] from_byte,
  input  logic [ecb_pkg::CH_W-1:0] to_byte,
  input  logic [FRAC_BITS:0]       ease,
  output logic [ecb_pkg::CH_W-1:0] lane_byte
);
  import ecb_pkg::*;

  localparam int AW = FRAC_BITS + CH_W + 3;

  logic signed [FRAC_BITS+1:0] ease_s;
  logic signed [CH_W:0]        diff_s;
  logic signed [AW-1:0]        prod;
  logic signed [AW-1:0]        base;
  logic signed [AW-1:0]        half;
  logic signed [AW-1:0]        acc;
  logic [CH_W-1:0]             lane_byte_r;

  assign ease_s = $signed({1'b0, ease});
  assign diff_s = $signed({1'b0, to_byte}) - $signed({1'b0, from_byte});
  assign prod   = ease_s * diff_s;
  assign base   = $signed({{(AW - CH_W - FRAC_BITS){1'b0}}, from_byte, {FRAC_BITS{1'b0}}});
  assign half   = $signed(AW'(1) << (FRAC_BITS - 1));
  assign acc    = base + prod + half;

  // acc never goes negative, so the byte above the fraction is the result
  always_ff @(posedge clk) begin
    if (en) begin
      lane_byte_r <= acc[FRAC_BITS +: CH_W];
    end
  end

  assign lane_byte = lane_byte_r;

endmodule

`default_nettype wire

>>> rtl/ease_in_out_colour_blend.sv
// ----------------------------------------------------------------------------
// ease_in_out_colour_blend: six-channel ease-in-out light blend
// blends a start light state toward a target along a quadratic ease curve
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each input beat carries a progress value
// (unsigned Q1.16, anything above 1.0 is treated as 1.0); the block computes
// ease = c^2 / (2c^2 - 2c + 1) to FRAC_BITS fraction bits, truncating, and
// for each of the six channels (level, red, green, blue, warm, cold) returns
// from + ease*(to - from) rounded half up. A new beat is taken every cycle
// unless back-pressure has filled every stage; ease comes from the restoring
// divider that produces one quotient bit per pipeline stage. Stages collapse
// bubbles, so input is still taken while a finished result waits at the
// output. Start and target states are written through the cfg port (index 0
// start, index 1 target, byte 0 is level); write them only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ease_in_out_colour_blend #(
  parameter int FRAC_BITS = ecb_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ecb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecb_pkg::COLOUR_W-1:0]     cfg_data,
  // progress beats
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ecb_pkg::PROGRESS_W-1:0]   in_progress,
  // blended light state beats
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ecb_pkg::CH_W-1:0]         out_level_out,
  output logic [ecb_pkg::CH_W-1:0]         out_red_out,
  output logic [ecb_pkg::CH_W-1:0]         out_green_out,
  output logic [ecb_pkg::CH_W-1:0]         out_blue_out,
  output logic [ecb_pkg::CH_W-1:0]         out_warm_out,
  output logic [ecb_pkg::CH_W-1:0]         out_cold_out
);
  import ecb_pkg::*;

  logic [COLOUR_W-1:0] start_r;
  logic [COLOUR_W-1:0] target_r;
  logic                out_valid_r;

  logic                ease_valid;
  logic                ease_ready;
  logic [FRAC_BITS:0]  ease;
  logic                lane_en;
  logic [CH_W-1:0]     lane_byte [0:CHANNELS-1];

  // config registers, always ready; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      target_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START) begin
        start_r <= cfg_data;
      end else if (cfg_index == REG_TARGET) begin
        target_r <= cfg_data;
      end
    end
  end

  // shared ease curve pipeline
  ecb_ease #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ease (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .progress   (in_progress),
    .ease_valid (ease_valid),
    .ease_ready (ease_ready),
    .ease       (ease)
  );

  // output stage loads when empty or being drained
  assign ease_ready = !out_valid_r || out_ready;
  assign lane_en    = ease_valid && ease_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ease_ready) begin
      out_valid_r <= ease_valid;
    end
  end

  // six blend lanes share one ease value; their registers form the output
  genvar gk;
  generate
    for (gk = 0; gk < CHANNELS; gk++) begin : g_lane
      ecb_lane #(
        .FRAC_BITS (FRAC_BITS)
      ) u_lane (
        .clk       (clk),
        .en        (lane_en),
        .from_byte (start_r[gk*CH_W +: CH_W]),
        .to_byte   (target_r[gk*CH_W +: CH_W]),
        .ease      (ease),
        .lane_byte (lane_byte[gk])
      );
    end
  endgenerate

  // merge lanes into the result beat
  assign out_valid     = out_valid_r;
  assign out_level_out = lane_byte[0];
  assign out_red_out   = lane_byte[1];
  assign out_green_out = lane_byte[2];
  assign out_blue_out  = lane_byte[3];
  assign out_warm_out  = lane_byte[4];
  assign out_cold_out  = lane_byte[5];

endmodule

`default_nettype wire

>>> rtl/ecb_checker.sv
// ----------------------------------------------------------------------------
// ecb_checker: port-level checks for the colour blend
// watches handshakes and reset behavior from the top level's ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecb_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     cfg_ready,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ecb_pkg::CH_W-1:0] out_level_out,
  input logic [ecb_pkg::CH_W-1:0] out_red_out,
  input logic [ecb_pkg::CH_W-1:0] out_green_out,
  input logic [ecb_pkg::CH_W-1:0] out_blue_out,
  input logic [ecb_pkg::CH_W-1:0] out_warm_out,
  input logic [ecb_pkg::CH_W-1:0] out_cold_out
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level_out)
      && $stable(out_red_out) && $stable(out_green_out)
      && $stable(out_blue_out) && $stable(out_warm_out)
      && $stable(out_cold_out))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // with the output free every stage can move, so input is taken
  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind ease_in_out_colour_blend ecb_checker u_ecb_checker (.*);

`default_nettype wire
